// ===== rtl/tcgr_pkg.sv =====
package tcgr_pkg;

  localparam int unsigned TextColsDef   = 40;
  localparam int unsigned TextRowsDef   = 30;
  localparam int unsigned GlyphCountDef = 256;

  localparam int unsigned QueueDepth = 2;

  localparam logic [7:0] CodeNewline = 8'd10;
  localparam logic       ModeLoad    = 1'b1;

  localparam logic CfgFgColour = 1'b0;
  localparam logic CfgBgColour = 1'b1;

  localparam logic [15:0] FgColourReset = 16'hFFFF;
  localparam logic [15:0] BgColourReset = 16'h0000;

  typedef struct packed {
    logic       mode;
    logic [7:0] char_code;
    logic [10:0] font_addr;
    logic [7:0] font_byte;
  } in_item_t;

  typedef struct packed {
    logic        is_window;
    logic [8:0]  x_start;
    logic [7:0]  y_start;
    logic [8:0]  x_end;
    logic [7:0]  y_end;
    logic [15:0] pixel_a;
    logic [15:0] pixel_b;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic        is_load;
    logic [10:0] addr;
    logic [7:0]  data;
    logic        blank;
    logic [5:0]  col;
    logic [4:0]  row;
  } cmd_t;

  typedef enum logic [1:0] {
    BackIdle,
    BackWindow,
    BackPixels
  } back_state_e;

endpackage

// ===== rtl/tcgr_front.sv =====
module tcgr_front #(
  parameter int unsigned TextCols   = tcgr_pkg::TextColsDef,
  parameter int unsigned TextRows   = tcgr_pkg::TextRowsDef,
  parameter int unsigned GlyphCount = tcgr_pkg::GlyphCountDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  tcgr_pkg::in_item_t in_data_i,
  input  logic               full_i,
  output logic               push_o,
  output tcgr_pkg::cmd_t     cmd_o
);

  logic [5:0] col_q, col_d;
  logic [4:0] row_q, row_d;
  logic       accept;
  logic [4:0] row_next;
  logic [6:0] col_inc;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;
  assign row_next   = (row_q < 5'(TextRows)) ? row_q + 5'd1 : row_q;
  assign col_inc    = {1'b0, col_q} + 7'd1;

  always_comb begin
    col_d         = col_q;
    row_d         = row_q;
    push_o        = 1'b0;
    cmd_o.is_load = (in_data_i.mode == tcgr_pkg::ModeLoad);
    cmd_o.addr    = in_data_i.font_addr;
    cmd_o.data    = in_data_i.font_byte;
    cmd_o.blank   = ({1'b0, in_data_i.char_code} >= 9'(GlyphCount));
    cmd_o.col     = col_q;
    cmd_o.row     = row_q;
    if (in_data_i.mode != tcgr_pkg::ModeLoad) begin
      cmd_o.addr = {in_data_i.char_code, 3'b000};
    end
    if (accept) begin
      if (in_data_i.mode == tcgr_pkg::ModeLoad) begin
        push_o = ({1'b0, in_data_i.font_addr} < 12'(GlyphCount * 8));
      end else if (in_data_i.char_code == tcgr_pkg::CodeNewline) begin
        col_d = '0;
        row_d = row_next;
      end else begin
        push_o = (col_q < 6'(TextCols)) && (row_q < 5'(TextRows));
        if (col_inc >= 7'(TextCols)) begin
          col_d = '0;
          row_d = row_next;
        end else begin
          col_d = col_inc[5:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

// ===== rtl/tcgr_fifo.sv =====
module tcgr_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  tcgr_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output tcgr_pkg::cmd_t cmd_o
);

  localparam int unsigned PtrW = $clog2(tcgr_pkg::QueueDepth);

  tcgr_pkg::cmd_t mem_q [tcgr_pkg::QueueDepth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [PtrW:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == (PtrW+1)'(tcgr_pkg::QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign cmd_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(tcgr_pkg::QueueDepth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(tcgr_pkg::QueueDepth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + (PtrW+1)'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - (PtrW+1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o || pop_i) else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("queue read while empty");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> cnt_q == $past(cnt_q) + (PtrW+1)'(1))
    else $error("queue count did not follow a write");

endmodule

// ===== rtl/tcgr_back.sv =====
module tcgr_back #(
  parameter int unsigned GlyphCount = tcgr_pkg::GlyphCountDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                empty_i,
  input  tcgr_pkg::cmd_t      cmd_i,
  output logic                pop_o,
  input  logic [15:0]         fg_colour_i,
  input  logic [15:0]         bg_colour_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output tcgr_pkg::out_item_t out_data_o
);

  localparam int unsigned FontDepth = GlyphCount * 8;
  localparam int unsigned FontAw    = $clog2(FontDepth);

  tcgr_pkg::back_state_e state_q, state_d;
  logic [7:0]        font_mem [FontDepth];
  logic [7:0]        rdata_q;
  logic              we, re;
  logic [FontAw-1:0] raddr;
  logic [FontAw-4:0] glyph_q, glyph_d;
  logic              blank_q, blank_d;
  logic [5:0]        col_q, col_d;
  logic [4:0]        row_q, row_d;
  logic [4:0]        k_q, k_d;
  logic              adv;
  logic [7:0]        bits, shifted;
  tcgr_pkg::out_item_t out_q, out_d;
  logic              out_valid_q, out_valid_d;

  assign adv         = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign bits        = blank_q ? 8'h00 : rdata_q;
  assign shifted     = bits << {k_q[1:0], 1'b0};

  always_comb begin
    state_d = state_q;
    case (state_q)
      tcgr_pkg::BackIdle: begin
        if (!empty_i && !cmd_i.is_load) begin
          state_d = tcgr_pkg::BackWindow;
        end
      end
      tcgr_pkg::BackWindow: begin
        if (adv) begin
          state_d = tcgr_pkg::BackPixels;
        end
      end
      tcgr_pkg::BackPixels: begin
        if (adv && k_q == 5'd31) begin
          state_d = tcgr_pkg::BackIdle;
        end
      end
      default: state_d = tcgr_pkg::BackIdle;
    endcase
  end

  always_comb begin
    pop_o       = 1'b0;
    we          = 1'b0;
    re          = 1'b0;
    raddr       = {glyph_q, k_q[4:2] + 3'd1};
    glyph_d     = glyph_q;
    blank_d     = blank_q;
    col_d       = col_q;
    row_d       = row_q;
    k_d         = k_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      tcgr_pkg::BackIdle: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          if (cmd_i.is_load) begin
            we = 1'b1;
          end else begin
            re      = 1'b1;
            raddr   = {cmd_i.addr[FontAw-1:3], 3'b000};
            glyph_d = cmd_i.addr[FontAw-1:3];
            blank_d = cmd_i.blank;
            col_d   = cmd_i.col;
            row_d   = cmd_i.row;
          end
        end
      end
      tcgr_pkg::BackWindow: begin
        if (adv) begin
          out_valid_d     = 1'b1;
          out_d           = '0;
          out_d.is_window = 1'b1;
          out_d.x_start   = {col_q, 3'b000};
          out_d.y_start   = {row_q, 3'b000};
          out_d.x_end     = {col_q, 3'b111};
          out_d.y_end     = {row_q, 3'b111};
          k_d             = '0;
        end
      end
      tcgr_pkg::BackPixels: begin
        if (adv) begin
          out_valid_d   = 1'b1;
          out_d         = '0;
          out_d.pixel_a = shifted[7] ? fg_colour_i : bg_colour_i;
          out_d.pixel_b = shifted[6] ? fg_colour_i : bg_colour_i;
          out_d.last    = (k_q == 5'd31);
          k_d           = k_q + 5'd1;
          re            = (k_q[1:0] == 2'd3) && (k_q != 5'd31);
        end
      end
      default: begin
        out_valid_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      font_mem[cmd_i.addr[FontAw-1:0]] <= cmd_i.data;
    end
    if (re) begin
      rdata_q <= font_mem[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    glyph_q <= glyph_d;
    blank_q <= blank_d;
    col_q   <= col_d;
    row_q   <= row_d;
    out_q   <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tcgr_pkg::BackIdle;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_pop_idle_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> state_q == tcgr_pkg::BackIdle) else $error("command taken while busy");

  a_window_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tcgr_pkg::BackWindow && adv) |=> out_valid_q && out_q.is_window)
    else $error("window item not issued");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tcgr_pkg::BackPixels && adv && k_q == 5'd31) |=>
      state_q == tcgr_pkg::BackIdle && out_q.last)
    else $error("glyph did not end after its final pair");

endmodule

// ===== rtl/text_console_glyph_renderer.sv =====
// Text console glyph renderer for a character-cell display.
// Input items arrive on in_valid_i / in_stall_o / in_data_i. A load item writes
// one byte of the font store. A print item moves the cursor and, when the cursor
// lies inside the text area, draws one character cell.
// A drawn character gives 33 result items on out_valid_o / out_stall_i /
// out_data_o: one window item with the cell rectangle, then 32 pixel pairs in
// raster order, the final pair marked by last.
// With the queue empty and the back end idle, an accepted input item passes
// through the command queue to the back end's idle state, which reads the first
// font row, and its window item is registered from the window state. With the
// output never stalled, one result item per cycle then follows from the single
// font memory read port; the next command is taken only in the idle state,
// as are loads; newlines and off-screen characters never enter the queue.
// A two-entry command queue lets the input side run ahead by two items.
// Colours are written on cfg_we_i / cfg_idx_i / cfg_data_i while the block
// idles; the user must keep to this, as the block does not enforce it. Reset
// puts the cursor at the top-left cell, empties the queue and sets the colours
// to white on black; the font store holds nothing until loaded.
// A pending result holds while out_stall_i is high; a full queue stalls input.
module text_console_glyph_renderer #(
  parameter int unsigned TextCols   = tcgr_pkg::TextColsDef,
  parameter int unsigned TextRows   = tcgr_pkg::TextRowsDef,
  parameter int unsigned GlyphCount = tcgr_pkg::GlyphCountDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  tcgr_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output tcgr_pkg::out_item_t out_data_o,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [15:0]         cfg_data_i
);

  logic [15:0]    fg_q, fg_d, bg_q, bg_d;
  logic           full, empty, push, pop;
  tcgr_pkg::cmd_t push_cmd, pop_cmd;

  always_comb begin
    fg_d = fg_q;
    bg_d = bg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        tcgr_pkg::CfgFgColour: fg_d = cfg_data_i;
        tcgr_pkg::CfgBgColour: bg_d = cfg_data_i;
        default: fg_d = fg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fg_q <= tcgr_pkg::FgColourReset;
      bg_q <= tcgr_pkg::BgColourReset;
    end else begin
      fg_q <= fg_d;
      bg_q <= bg_d;
    end
  end

  tcgr_front #(
    .TextCols   (TextCols),
    .TextRows   (TextRows),
    .GlyphCount (GlyphCount)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .full_i     (full),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  tcgr_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .cmd_o   (pop_cmd)
  );

  tcgr_back #(
    .GlyphCount (GlyphCount)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .cmd_i       (pop_cmd),
    .pop_o       (pop),
    .fg_colour_i (fg_q),
    .bg_colour_i (bg_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
